### design/assert_macros.svh
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### design/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared types and constants of the decimal text converter.
// ----------------------------------------------------------------------------
package u2da_pkg;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] LINE_FEED  = 8'd10;
  localparam int         MAX_DIGITS = 20;

  // Control passed from the sequencer to the cell chain.
  typedef struct packed {
    logic load;   // take a new value into the chain
    logic shift;  // advance the chain by one input bit
  } chain_ctl_t;
endpackage

### design/u2da_cell.sv
// ----------------------------------------------------------------------------
// u2da_cell
// One BCD digit of a double-dabble chain: add-3 correction, then shift left.
// ----------------------------------------------------------------------------
module u2da_cell (
  input  logic                 clk,
  input  u2da_pkg::chain_ctl_t ctl,
  input  logic                 carry_in,
  output logic                 carry_out,
  output logic [3:0]           digit
);
  import u2da_pkg::*;

  logic [3:0] adj;

  // Correct digits of five or more before the shift.
  assign adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adj[3];

  // Clear on load, shift one bit in per step.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      digit <= '0;
    end else if (ctl.shift) begin
      digit <= {adj[2:0], carry_in};
    end
  end
endmodule

### design/unsigned_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Converts an unsigned value to decimal ASCII text ending in a line feed.
// ----------------------------------------------------------------------------
// channel | ports                                  | per transfer
// input   | value; in_valid, in_stall              | one value
// output  | text_byte, last; out_valid, out_stall  | one text byte
// An accepted value shifts all VALUE_WIDTH bits through 20 digit cells.
// Output then visits each digit cell once from the top: leading zeros
// pass with no transfer, then the line feed is sent. Output stall holds
// the current byte; the next value is accepted once the line feed has
// been transferred. Reset returns to idle.
module unsigned_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] value,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [7:0]  text_byte,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);
  import u2da_pkg::*;

  localparam int          CW = $clog2(VALUE_WIDTH + 1);
  localparam logic [1:0]  S_IDLE = 2'd0;
  localparam logic [1:0]  S_CONV = 2'd1;
  localparam logic [1:0]  S_OUT  = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] sreg;
  logic [CW-1:0]          cnt;
  logic [4:0]             pos;
  logic                   started;
  chain_ctl_t             ctl;
  logic [MAX_DIGITS:0]    carry;
  logic [3:0]             digs [MAX_DIGITS];
  logic [3:0]             cur;
  logic                   in_take;
  logic                   out_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign ctl.load  = in_take;
  assign ctl.shift = (state == S_CONV);
  assign carry[0]  = sreg[VALUE_WIDTH-1];

  // Build the chain of digit cells, least significant first.
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    u2da_cell u_cell (
      .clk(clk), .ctl(ctl), .carry_in(carry[i]),
      .carry_out(carry[i+1]), .digit(digs[i])
    );
  end

  assign cur       = digs[pos];
  assign last      = (pos == 5'd31);
  assign text_byte = last ? LINE_FEED : (ASCII_ZERO + {4'd0, cur});
  assign out_valid = (state == S_OUT) && (last || started || cur != 4'd0 || pos == 5'd0);

  // Sequence load, conversion and byte output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            sreg  <= value[VALUE_WIDTH-1:0];
            cnt   <= CW'(VALUE_WIDTH);
            state <= S_CONV;
          end
        end
        S_CONV: begin
          sreg <= {sreg[VALUE_WIDTH-2:0], 1'b0};
          cnt  <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            pos     <= 5'(MAX_DIGITS - 1);
            started <= 1'b0;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (last) begin
            if (out_take) state <= S_IDLE;
          end else if (out_take) begin
            started <= 1'b1;
            pos     <= (pos == 5'd0) ? 5'd31 : pos - 1'b1;
          end else if (!out_valid) begin
            pos <= pos - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/u2da_checker.sv
// ----------------------------------------------------------------------------
// u2da_checker
// Port-level checks of the decimal text converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module u2da_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] text_byte,
  input logic       last,
  input logic       out_valid,
  input logic       out_stall
);
  import u2da_pkg::*;

  `ASSERT_IMPLY(a_last_lf, clk, rst, out_valid && last, text_byte == LINE_FEED)
  `ASSERT_IMPLY(a_digit_range, clk, rst, out_valid && !last,
                text_byte >= ASCII_ZERO && text_byte <= ASCII_ZERO + 8'd9)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
               out_valid && $stable(text_byte) && $stable(last))
  `ASSERT_IMPLY(a_busy, clk, rst, out_valid, in_stall)
endmodule

bind unsigned_to_decimal_ascii u2da_checker u_chk (.*);

### tb/tb_unsigned_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// tb_unsigned_to_decimal_ascii
// Sends unsigned values with bursty gaps and checks every decimal text byte
// and its last flag against a local digit-peeling predictor, under a random
// output stall pattern.
// ----------------------------------------------------------------------------
module tb_unsigned_to_decimal_ascii;
  import u2da_pkg::*;

  localparam int VALUE_WIDTH = 64;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } text_item_t;

  logic        clk;
  logic        rst;
  logic [63:0] value;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  text_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;

  text_item_t expected_text[$];
  int         mismatch_count;
  int         byte_count;
  int         value_count;
  int         idle_cycles;
  int         stall_mode;

  unsigned_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
    .clk(clk), .rst(rst), .value(value), .in_valid(in_valid),
    .in_stall(in_stall), .text_byte(text_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predict the decimal text of one value: digits high first, then line feed.
  task automatic predict_decimal_text(input logic [63:0] v_in);
    logic [7:0] digits[MAX_DIGITS];
    logic [63:0] v;
    text_item_t t;
    int n;
    v = v_in;
    if (VALUE_WIDTH < 64) v = v & ((64'd1 << VALUE_WIDTH) - 64'd1);
    n = 0;
    do begin
      digits[n] = ASCII_ZERO + 8'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      t.text_byte = digits[k];
      t.last = 1'b0;
      expected_text.push_back(t);
    end
    t.text_byte = LINE_FEED;
    t.last = 1'b1;
    expected_text.push_back(t);
  endtask

  // Drive one value and hold it until the transfer; gap after by burst pattern.
  int burst_left;
  task automatic send_value(input logic [63:0] v);
    value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_decimal_text(v);
    value_count++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  endtask

  // Receiver stall pattern; mode changes now and then.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Check each transferred byte against the oldest expectation.
  always @(posedge clk) begin
    text_item_t exp_t;
    if (!rst && out_valid && !out_stall) begin
      byte_count++;
      if (expected_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected byte %0d last %0b", text_byte, last);
      end else begin
        exp_t = expected_text.pop_front();
        if (text_byte !== exp_t.text_byte || last !== exp_t.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("byte mismatch: expected %0d/%0b got %0d/%0b",
                     exp_t.text_byte, exp_t.last, text_byte, last);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("unsigned_to_decimal_ascii test failed");
      $finish;
    end
  end

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int digits_bits;
    v = {$urandom, $urandom};
    digits_bits = $urandom_range(1, 64);
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >> (64 - digits_bits);
      2: return 64'(10) ** $urandom_range(0, 19) - 64'($urandom_range(0, 1));
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic test_extremes();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd9999999999999999999);
    send_value(64'd10000000000000000000);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'hFFFF_FFFF_FFFF_FFFE);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h0000_0000_FFFF_FFFF);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
  endtask

  task automatic test_random_values();
    repeat (395) send_value(random_value());
  endtask

  initial begin
    rst = 1'b1;
    value = 64'd0;
    in_valid = 1'b0;
    stall_mode = 0;
    burst_left = 0;
    mismatch_count = 0;
    byte_count = 0;
    value_count = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_random_values();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("converted %0d values into %0d text bytes, %0d mismatches",
             value_count, byte_count, mismatch_count);
    $display("covered zero, digit-count boundaries and full 64-bit range");
    if (mismatch_count == 0 && expected_text.size() == 0)
      $display("unsigned_to_decimal_ascii test passed");
    else
      $display("unsigned_to_decimal_ascii test failed");
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/u2da_pkg.sv
design/u2da_cell.sv
design/unsigned_to_decimal_ascii.sv
design/u2da_checker.sv
tb/tb_unsigned_to_decimal_ascii.sv
